>>> design/deq_pkg.sv
`default_nettype none
package deq_pkg;

   localparam int Depth      = 16;
   localparam int DataWidth  = 32;
   localparam int IndexWidth = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   typedef logic signed [DataWidth-1:0] data_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [IndexWidth-1:0] index_type;

   typedef enum logic [1:0] {
      CmdPushFront = 2'd0,
      CmdPopFront  = 2'd1,
      CmdPushBack  = 2'd2,
      CmdPopBack   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      StatusOk    = 2'd0,
      StatusEmpty = 2'd1,
      StatusFull  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SelHold  = 2'd0,
      SelLeft  = 2'd1,
      SelRight = 2'd2,
      SelPush  = 2'd3
   } cell_sel_type;

endpackage
`default_nettype wire

>>> design/deq_cell.sv
`default_nettype none
module deq_cell (
   input  wire                    clock,
   input  deq_pkg::cell_sel_type  sel,
   input  deq_pkg::data_type      left_data,
   input  deq_pkg::data_type      right_data,
   input  deq_pkg::data_type      push_data,
   output deq_pkg::data_type      data
);
   import deq_pkg::*;

   data_type data_ff;
   data_type data_in;

   always_comb begin
      unique case (sel)
         SelHold:  data_in = data_ff;
         SelLeft:  data_in = left_data;
         SelRight: data_in = right_data;
         SelPush:  data_in = push_data;
         default:  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

>>> design/double_ended_queue.sv
`default_nettype none
// Double-ended queue of up to 16 signed 32-bit values, held in a row of cells
// with the front entry in the first cell. Each request transfer carries a
// command in req_tuser and a value in req_tdata and gives exactly one response:
// the popped value (zero unless a pop succeeded), a status (ok, pop on empty,
// push on full) and the entry count after the step. A push at the front shifts
// every cell one place toward the back, a pop at the front shifts one place
// toward the front, and the back end is written or read at the cell the count
// selects. A request is taken every cycle unless the response stalls; the
// response appears the cycle after its request in an output register, so a
// new request is taken when that register is empty or drained in that cycle.
module double_ended_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] push_value
   input  wire  [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] popped_value, [36:32] count_after
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import deq_pkg::*;

   data_type     cells [Depth];
   cell_sel_type sel [Depth];

   count_type  count_ff;
   count_type  count_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   data_type   rsp_value_ff;
   data_type   rsp_value_in;
   status_type rsp_status_ff;
   status_type rsp_status_in;
   count_type  rsp_count_ff;

   logic      accept;
   cmd_type   cmd;
   data_type  push_data;
   index_type back_idx;
   index_type last_idx;
   logic      full;
   logic      empty;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign push_data  = data_type'(req_tdata);
   assign full       = (count_ff == count_type'(Depth));
   assign empty      = (count_ff == '0);
   assign back_idx   = count_ff[IndexWidth-1:0];
   assign last_idx   = index_type'(count_ff - count_type'(1));

   always_comb begin
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_status_in = StatusOk;
      for (int i = 0; i < Depth; i++) begin
         sel[i] = SelHold;
      end
      unique case (cmd)
         CmdPushFront: begin
            if (full) begin
               rsp_status_in = StatusFull;
            end else begin
               for (int i = 0; i < Depth; i++) begin
                  sel[i] = (i == 0) ? SelPush : SelLeft;
               end
               count_in = count_ff + count_type'(1);
            end
         end
         CmdPopFront: begin
            if (empty) begin
               rsp_status_in = StatusEmpty;
            end else begin
               rsp_value_in = cells[0];
               for (int i = 0; i < Depth; i++) begin
                  sel[i] = SelRight;
               end
               count_in = count_ff - count_type'(1);
            end
         end
         CmdPushBack: begin
            if (full) begin
               rsp_status_in = StatusFull;
            end else begin
               for (int i = 0; i < Depth; i++) begin
                  if (index_type'(i) == back_idx) begin
                     sel[i] = SelPush;
                  end
               end
               count_in = count_ff + count_type'(1);
            end
         end
         CmdPopBack: begin
            if (empty) begin
               rsp_status_in = StatusEmpty;
            end else begin
               rsp_value_in = cells[last_idx];
               count_in     = count_ff - count_type'(1);
            end
         end
         default: begin
            rsp_status_in = StatusOk;
         end
      endcase
      // hold every cell unless a transfer is taken
      if (!accept) begin
         for (int i = 0; i < Depth; i++) begin
            sel[i] = SelHold;
         end
         count_in = count_ff;
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   for (genvar g = 0; g < Depth; g++) begin : g_cell
      deq_cell u_cell (
         .clock      (clock),
         .sel        (sel[g]),
         .left_data  ((g == 0) ? push_data : cells[(g == 0) ? 0 : g - 1]),
         .right_data (cells[(g == Depth - 1) ? g : g + 1]),
         .push_data  (push_data),
         .data       (cells[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire
